### hw/rtl/tty_output_conversion_assert.svh
// Assertion macros for the terminal output conversion back end.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TTY_OUTPUT_CONVERSION_ASSERT_SVH
`define TTY_OUTPUT_CONVERSION_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define TTY_OC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tty_oc assertion failed");

// Checks that a condition never holds outside of reset.
`define TTY_OC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tty_oc forbidden condition seen");

`endif

### hw/rtl/tty_oc_pkg.sv
// Shared types and constants of the terminal output conversion block.
// No dependencies; imported by every module of the block.
package tty_oc_pkg;

  // Tab stop spacing and the bits needed for a column offset within a stop.
  localparam int TabStop = 8;
  localparam int TabBits = $clog2(TabStop);

  // Default depth of the queue between front and back.
  localparam int QueueDepthDef = 2;

  // Character codes.
  localparam logic [7:0] ChrMask  = 8'h7F;
  localparam logic [7:0] CharBs    = 8'd8;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharVt    = 8'd11;
  localparam logic [7:0] CharFf    = 8'd12;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDel   = 8'd127;

  // Delay lengths in ticks.
  localparam logic [7:0] CrDlyShort  = 8'd5;
  localparam logic [7:0] CrDlyMid    = 8'd10;
  localparam logic [7:0] CrDlyLong   = 8'd20;
  localparam logic [7:0] NlDlyFixed  = 8'd6;
  localparam logic [7:0] NlDlyBase   = 8'd3;
  localparam logic [7:0] VertDly     = 8'd127;
  localparam logic [7:0] TabDlyMin   = 8'd5;

  // Mode codes of the configuration registers.
  localparam logic [1:0] NlDlyColumn  = 2'd1;
  localparam logic [1:0] NlDlySix     = 2'd2;
  localparam logic [1:0] TabDlyColumn = 2'd1;
  localparam logic [1:0] TabExpand    = 2'd3;
  localparam logic [1:0] CrDlyFive    = 2'd1;
  localparam logic [1:0] CrDlyTen     = 2'd2;
  localparam logic [1:0] CrDlyTwenty  = 2'd3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RAW_MODE,
    REG_CRLF_MAP,
    REG_NL_DELAY,
    REG_TAB_MODE,
    REG_CR_DELAY,
    REG_VERT_DELAY
  } reg_idx_e;

  // Character classes.
  typedef enum logic [2:0] {
    CLS_ORD,
    CLS_NONPRINT,
    CLS_BS,
    CLS_NL,
    CLS_TAB,
    CLS_VERT,
    CLS_CR
  } cls_e;

  // Sequencer phases of the back end.
  typedef enum logic [1:0] {
    PH_PRE_CHR,
    PH_PRE_DLY,
    PH_MAIN_CHR,
    PH_MAIN_DLY
  } phase_e;

  // Configuration register set.
  typedef struct packed {
    logic       raw_mode;
    logic       crlf_map;
    logic [1:0] nl_dly_mode;
    logic [1:0] tab_mode;
    logic [1:0] cr_dly_mode;
    logic       vert_dly;
  } cfg_t;

  // One classified item: an optional CR prefix with its delay, a character
  // sent one or more times, and an optional trailing delay (zero for none).
  typedef struct packed {
    logic               pre_en;
    logic [7:0]         pre_dly;
    logic [7:0]         chr;
    logic [TabBits-1:0] rep_m1;
    logic [7:0]         dly;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

endpackage

### hw/rtl/tty_output_conversion.sv
// Terminal output conversion: an accepted byte is written to the command queue, from which
// the back end loads its results into the output register. One byte per cycle is accepted
// when each makes one result; a byte with several results occupies the back-end sequencer
// until its last result is loaded, and input stalls once the command queue (QueueDepth
// entries) is full. Reset clears the cursor column, sets all registers to their defaults
// (newline mapping on) and empties the queue and the output register.
module tty_output_conversion
  import tty_oc_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [1:0] cfg_wdata_i,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] out_byte
  // Output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] item_value
  output logic [0:0] m_axis_tuser,   // [0] item_kind
  output logic       m_axis_tlast
);

  cfg_t      cfg_q;
  logic      push_valid, push_ready;
  cmd_t      push_cmd;
  logic      cmd_valid, cmd_pop;
  cmd_t      cmd_head;
  out_item_t out_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_mode    <= 1'b0;
      cfg_q.crlf_map    <= 1'b1;
      cfg_q.nl_dly_mode <= 2'd0;
      cfg_q.tab_mode    <= 2'd0;
      cfg_q.cr_dly_mode <= 2'd0;
      cfg_q.vert_dly    <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RAW_MODE:   cfg_q.raw_mode    <= cfg_wdata_i[0];
        REG_CRLF_MAP:   cfg_q.crlf_map    <= cfg_wdata_i[0];
        REG_NL_DELAY:   cfg_q.nl_dly_mode <= cfg_wdata_i;
        REG_TAB_MODE:   cfg_q.tab_mode    <= cfg_wdata_i;
        REG_CR_DELAY:   cfg_q.cr_dly_mode <= cfg_wdata_i;
        REG_VERT_DELAY: cfg_q.vert_dly    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tty_oc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  tty_oc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_i        (cmd_pop),
    .pop_cmd_o    (cmd_head)
  );

  tty_oc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign s_axis_tready   = push_ready;
  assign m_axis_tdata    = out_item.value;
  assign m_axis_tuser[0] = out_item.kind;
  assign m_axis_tlast    = out_item.last;

endmodule

### hw/rtl/tty_oc_front.sv
// Front end: accepts input bytes, classes them, tracks the cursor column
// and hands one command per byte to the queue. Depends on tty_oc_pkg.
module tty_oc_front
  import tty_oc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       push_ready_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o
);

  logic [7:0]         cursor_col_q, cursor_col_d;
  logic [7:0]         chr7;
  cls_e               cls;
  logic [TabBits-1:0] rem;
  logic [7:0]         tab_step;
  logic [7:0]         tab_dly;
  cmd_t               cmd;
  logic               accept;

  // Standard ASCII classes of a 7-bit character.
  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if (c == CharBs) r = CLS_BS;
    else if (c == CharTab) r = CLS_TAB;
    else if (c == CharLf) r = CLS_NL;
    else if (c == CharVt || c == CharFf) r = CLS_VERT;
    else if (c == CharCr) r = CLS_CR;
    else if (c < CharSpace || c == CharDel) r = CLS_NONPRINT;
    else r = CLS_ORD;
    return r;
  endfunction

  // Delay after a carriage return.
  function automatic logic [7:0] cr_delay(input logic [1:0] mode);
    logic [7:0] d;
    case (mode)
      CrDlyFive:   d = CrDlyShort;
      CrDlyTen:    d = CrDlyMid;
      CrDlyTwenty: d = CrDlyLong;
      default:     d = 8'd0;
    endcase
    return d;
  endfunction

  // Delay after a line feed, given the column it is sent at.
  function automatic logic [7:0] nl_delay(input logic [1:0] mode, input logic [7:0] col);
    logic [7:0] d;
    d = 8'd0;
    case (mode)
      NlDlyColumn: begin
        if (col != 8'd0) begin
          d = (col >> 4) + NlDlyBase;
          if (d < NlDlyFixed) d = NlDlyFixed;
        end
      end
      NlDlySix: d = NlDlyFixed;
      default:  d = 8'd0;
    endcase
    return d;
  endfunction

  assign accept = in_valid_i && push_ready_i;

  // Tab arithmetic on the current column.
  assign chr7     = in_byte_i & ChrMask;
  assign cls      = classify(chr7);
  assign rem      = cursor_col_q[TabBits-1:0];
  assign tab_step = 8'(TabStop) - 8'(rem);
  assign tab_dly  = 8'(TabStop + 1) - 8'(rem);

  // Build the command and the next column.
  always_comb begin
    cmd          = '0;
    cmd.chr      = chr7;
    cursor_col_d = cursor_col_q;
    if (cfg_i.raw_mode) begin
      cmd.chr = in_byte_i;
    end else begin
      case (cls)
        CLS_ORD: begin
          cursor_col_d = cursor_col_q + 8'd1;
        end
        CLS_BS: begin
          if (cursor_col_q != 8'd0) cursor_col_d = cursor_col_q - 8'd1;
        end
        CLS_NL: begin
          if (cfg_i.crlf_map) begin
            // CR goes first and resets the column; LF delay then sees column zero.
            cmd.pre_en  = 1'b1;
            cmd.pre_dly = cr_delay(cfg_i.cr_dly_mode);
            cmd.dly     = nl_delay(cfg_i.nl_dly_mode, 8'd0);
          end else begin
            cmd.dly = nl_delay(cfg_i.nl_dly_mode, cursor_col_q);
          end
          cursor_col_d = 8'd0;
        end
        CLS_TAB: begin
          if (cfg_i.tab_mode == TabExpand) begin
            cmd.chr    = CharSpace;
            cmd.rep_m1 = TabBits'(TabStop - 1) - rem;
          end else if (cfg_i.tab_mode == TabDlyColumn) begin
            cmd.dly = (tab_dly < TabDlyMin) ? 8'd0 : tab_dly;
          end
          cursor_col_d = cursor_col_q + tab_step;
        end
        CLS_VERT: begin
          cmd.dly = cfg_i.vert_dly ? VertDly : 8'd0;
        end
        CLS_CR: begin
          cmd.dly      = cr_delay(cfg_i.cr_dly_mode);
          cursor_col_d = 8'd0;
        end
        default: begin
          cursor_col_d = cursor_col_q;
        end
      endcase
    end
  end

  // Column register, updated on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= 8'd0;
    end else if (accept) begin
      cursor_col_q <= cursor_col_d;
    end
  end

  assign push_valid_o = in_valid_i;
  assign push_cmd_o   = cmd;

endmodule

### hw/rtl/tty_oc_queue.sv
// Short command queue between front and back ends.
// Depends on tty_oc_pkg for the command type.
module tty_oc_queue
  import tty_oc_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) count_d = count_q + CntW'(1);
    else if (pop_i && !push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

### hw/rtl/tty_oc_back.sv
// Back end: sequences each queued command into result items and holds
// them in an output register. Depends on tty_oc_pkg and the assert macros.
`include "tty_output_conversion_assert.svh"

module tty_oc_back
  import tty_oc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  phase_e             phase_q, phase_d, cur_phase;
  logic [TabBits-1:0] cnt_q, cnt_d;
  logic               out_valid_q;
  out_item_t          out_q;
  out_item_t          item;
  logic               load;

  // A fresh command without CR prefix starts at its main character.
  assign cur_phase = (phase_q == PH_PRE_CHR && !cmd_i.pre_en) ? PH_MAIN_CHR : phase_q;
  assign load      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = load && item.last;

  // Item produced in the current phase.
  always_comb begin
    item = '0;
    case (cur_phase)
      PH_PRE_CHR: begin
        item.value = CharCr;
      end
      PH_PRE_DLY: begin
        item.kind  = 1'b1;
        item.value = cmd_i.pre_dly;
      end
      PH_MAIN_CHR: begin
        item.value = cmd_i.chr;
        item.last  = (cnt_q == cmd_i.rep_m1) && (cmd_i.dly == 8'd0);
      end
      PH_MAIN_DLY: begin
        item.kind  = 1'b1;
        item.value = cmd_i.dly;
        item.last  = 1'b1;
      end
      default: begin
        item = '0;
      end
    endcase
  end

  // Next phase and repeat count.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (load) begin
      case (cur_phase)
        PH_PRE_CHR: begin
          phase_d = (cmd_i.pre_dly != 8'd0) ? PH_PRE_DLY : PH_MAIN_CHR;
        end
        PH_PRE_DLY: begin
          phase_d = PH_MAIN_CHR;
        end
        PH_MAIN_CHR: begin
          if (cnt_q != cmd_i.rep_m1) begin
            cnt_d = cnt_q + TabBits'(1);
          end else if (cmd_i.dly != 8'd0) begin
            phase_d = PH_MAIN_DLY;
          end else begin
            phase_d = PH_PRE_CHR;
            cnt_d   = '0;
          end
        end
        PH_MAIN_DLY: begin
          phase_d = PH_PRE_CHR;
          cnt_d   = '0;
        end
        default: begin
          phase_d = PH_PRE_CHR;
          cnt_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PRE_CHR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) out_q <= item;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A command leaves the queue only with its final item.
  `TTY_OC_ASSERT(pop_marks_last, cmd_pop_o |=> (out_valid_q && out_q.last))
  // After the final item the sequencer is back at its start.
  `TTY_OC_ASSERT(pop_restarts, cmd_pop_o |=> (phase_q == PH_PRE_CHR && cnt_q == '0))
  // Never pop an empty queue.
  `TTY_OC_NEVER(pop_when_empty, cmd_pop_o && !cmd_valid_i)

endmodule
